>>> rtl/core/mgsp_pkg.sv
// ----------------------------------------------------------------------------
// mgsp_pkg : shared definitions of the multistage graph shortest path block
// sizes, codes and entry layouts used by the top level and the relax unit
// ----------------------------------------------------------------------------
package mgsp_pkg;

   localparam int MAX_VERTICES  = 64;
   localparam int VERTEX_BITS   = $clog2(MAX_VERTICES);
   localparam int VCOUNT_BITS   = VERTEX_BITS + 1;
   localparam int WEIGHT_BITS   = 16;
   localparam int COST_BITS     = 22;
   localparam int ARC_ADDR_BITS = 2 * VERTEX_BITS;
   localparam int ARC_DEPTH     = MAX_VERTICES * MAX_VERTICES;
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 7;

   localparam logic [COST_BITS-1:0] INFINITY = '1;

   // request function codes
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_SOLVE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_VERTEX_COUNT  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEGMENT_COUNT = 1'b1;

   typedef struct packed {
      logic                   present;
      logic [WEIGHT_BITS-1:0] weight;
   } arc_entry_type;

   typedef struct packed {
      logic [VERTEX_BITS-1:0] succ;
      logic [COST_BITS-1:0]   cost;
   } cost_entry_type;

   typedef struct packed {
      logic                 take;
      logic [COST_BITS-1:0] cost;
   } relax_type;

endpackage

>>> rtl/core/mgsp_relax_unit.sv
// ----------------------------------------------------------------------------
// mgsp_relax_unit : shared add, saturate and compare unit
// adds an arc weight to a successor cost and tests it against the best so far
// ----------------------------------------------------------------------------
module mgsp_relax_unit (
   input  logic [mgsp_pkg::COST_BITS-1:0]   cand_cost,
   input  logic [mgsp_pkg::WEIGHT_BITS-1:0] arc_weight,
   input  logic                             arc_present,
   input  logic [mgsp_pkg::COST_BITS-1:0]   best_cost,
   output mgsp_pkg::relax_type              result
);
   import mgsp_pkg::*;

   logic [COST_BITS:0]   sum;
   logic [COST_BITS-1:0] sat;
   logic                 usable;

   // unreachable successors never compete
   assign usable = arc_present && (cand_cost != INFINITY);
   assign sum    = {1'b0, cand_cost} + {{(COST_BITS + 1 - WEIGHT_BITS){1'b0}}, arc_weight};
   assign sat    = sum[COST_BITS] ? INFINITY : sum[COST_BITS-1:0];

   // strict compare keeps the lowest numbered successor on a tie
   assign result.take = usable && (sat < best_cost);
   assign result.cost = sat;

endmodule

>>> rtl/core/multistage_graph_shortest_path.sv
// ----------------------------------------------------------------------------
// multistage_graph_shortest_path : backward dp shortest path over a multistage graph
// load transfers fill an arc store, a solve transfer relaxes it and streams the path
// ----------------------------------------------------------------------------
// timing: a load transfer is written as it is taken; a solve relaxes rows from the
//    sink back to vertex 0, then streams the path one result at a time, held on output stalls
// relaxation: each step reads the arc store and cost store through registered ports
//    (S_RD), then evaluates in the single shared relax unit (S_EV) before the next read
// reset: synchronous, active high; after reset and after each solve every entry of the
//    arc store is swept clear, during which no request is taken
// ----------------------------------------------------------------------------
module multistage_graph_shortest_path (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_func,
   input  logic [mgsp_pkg::VERTEX_BITS-1:0]    req_from_vertex,
   input  logic [mgsp_pkg::VERTEX_BITS-1:0]    req_to_vertex,
   input  logic [mgsp_pkg::WEIGHT_BITS-1:0]    req_arc_weight,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mgsp_pkg::VERTEX_BITS-1:0]    rsp_path_vertex,
   output logic [mgsp_pkg::COST_BITS-1:0]      rsp_path_cost,
   output logic                                rsp_unreachable,
   output logic                                rsp_last,
   // configuration port
   input  logic                                csr_wr_en,
   input  logic [mgsp_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [mgsp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mgsp_pkg::*;

   localparam logic [VCOUNT_BITS-1:0] VC_MIN = VCOUNT_BITS'(2);
   localparam logic [VCOUNT_BITS-1:0] VC_MAX = VCOUNT_BITS'(MAX_VERTICES);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ROW, S_RD, S_EV, S_WR, S_CHK, S_CHK2, S_PATH, S_OUT
   } state_type;

   state_type state_ff;

   // configuration registers
   logic [VCOUNT_BITS-1:0]   vertex_count_ff;
   logic [VCOUNT_BITS-1:0]   segment_count_ff;

   // sequencer registers
   logic [ARC_ADDR_BITS-1:0] clr_addr_ff;
   logic [VERTEX_BITS-1:0]   sink_ff;
   logic [VERTEX_BITS-1:0]   seg_last_ff;
   logic [VERTEX_BITS-1:0]   i_ff;
   logic [VERTEX_BITS-1:0]   j_ff;
   logic [COST_BITS-1:0]     best_ff;
   logic [VERTEX_BITS-1:0]   succ_ff;
   logic [VERTEX_BITS-1:0]   cur_ff;
   logic [VERTEX_BITS-1:0]   k_ff;
   logic [COST_BITS-1:0]     total_ff;

   // result registers
   logic                     rsp_valid_ff;
   logic [VERTEX_BITS-1:0]   rsp_path_vertex_ff;
   logic [COST_BITS-1:0]     rsp_path_cost_ff;
   logic                     rsp_unreachable_ff;
   logic                     rsp_last_ff;

   // memories
   arc_entry_type            arc_mem [ARC_DEPTH];
   arc_entry_type            arc_q_ff;
   cost_entry_type           cost_mem [MAX_VERTICES];
   cost_entry_type           cost_q_ff;

   logic                     req_accept;
   logic                     rsp_accept;
   logic [VCOUNT_BITS-1:0]   vc_new;
   logic [VCOUNT_BITS-1:0]   seg_new;
   logic [VCOUNT_BITS-1:0]   vc_dec;
   logic [VCOUNT_BITS-1:0]   seg_dec;
   logic [VERTEX_BITS-1:0]   sink_new;
   logic [VERTEX_BITS-1:0]   next_cur;

   logic                     arc_we;
   logic [ARC_ADDR_BITS-1:0] arc_waddr;
   arc_entry_type            arc_wdata;
   logic [ARC_ADDR_BITS-1:0] arc_raddr;
   logic                     cost_we;
   logic [VERTEX_BITS-1:0]   cost_waddr;
   cost_entry_type           cost_wdata;
   logic [VERTEX_BITS-1:0]   cost_raddr;

   relax_type                relax;

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE);

   // register clamping, taken at the start of a solve
   always_comb begin
      if (vertex_count_ff < VC_MIN) begin
         vc_new = VC_MIN;
      end else if (vertex_count_ff > VC_MAX) begin
         vc_new = VC_MAX;
      end else begin
         vc_new = vertex_count_ff;
      end
      if (segment_count_ff < VC_MIN) begin
         seg_new = VC_MIN;
      end else if (segment_count_ff > vc_new) begin
         seg_new = vc_new;
      end else begin
         seg_new = segment_count_ff;
      end
   end

   assign vc_dec   = vc_new - VCOUNT_BITS'(1);
   assign seg_dec  = seg_new - VCOUNT_BITS'(1);
   assign sink_new = vc_dec[VERTEX_BITS-1:0];

   // successor of the current path vertex, held on the cost store read port
   assign next_cur = (cost_q_ff.succ > sink_ff) ? sink_ff : cost_q_ff.succ;

   // arc store ports: sweep clear, arc load, relaxation read
   always_comb begin
      arc_we    = 1'b0;
      arc_waddr = {req_from_vertex, req_to_vertex};
      arc_wdata = '{present: 1'b1, weight: req_arc_weight};
      if (state_ff == S_CLEAR) begin
         arc_we    = 1'b1;
         arc_waddr = clr_addr_ff;
         arc_wdata = '{present: 1'b0, weight: '0};
      end else if (req_accept && (req_func == FUNC_LOAD)) begin
         // backward arcs and self-loops are dropped
         arc_we = (req_to_vertex > req_from_vertex);
      end
   end

   assign arc_raddr = {i_ff, j_ff};

   // cost store ports: sink seed, row result, relaxation and path reads
   always_comb begin
      cost_we    = 1'b0;
      cost_waddr = sink_new;
      cost_wdata = '{succ: sink_new, cost: '0};
      if (state_ff == S_WR) begin
         cost_we    = 1'b1;
         cost_waddr = i_ff;
         cost_wdata = '{succ: succ_ff, cost: best_ff};
      end else if (req_accept && (req_func == FUNC_SOLVE)) begin
         cost_we = 1'b1;
      end
   end

   always_comb begin
      unique case (state_ff)
         S_RD:    cost_raddr = j_ff;
         S_CHK:   cost_raddr = '0;
         default: cost_raddr = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (arc_we) begin
         arc_mem[arc_waddr] <= arc_wdata;
      end
      arc_q_ff <= arc_mem[arc_raddr];
   end

   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[cost_waddr] <= cost_wdata;
      end
      cost_q_ff <= cost_mem[cost_raddr];
   end

   mgsp_relax_unit u_relax (
      .cand_cost   (cost_q_ff.cost),
      .arc_weight  (arc_q_ff.weight),
      .arc_present (arc_q_ff.present),
      .best_cost   (best_ff),
      .result      (relax)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff  <= VCOUNT_BITS'(MAX_VERTICES);
         segment_count_ff <= VCOUNT_BITS'(2);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT:  vertex_count_ff  <= csr_wdata[VCOUNT_BITS-1:0];
            CSR_SEGMENT_COUNT: segment_count_ff <= csr_wdata[VCOUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               // one arc entry a cycle
               clr_addr_ff <= clr_addr_ff + ARC_ADDR_BITS'(1);
               if (clr_addr_ff == '1) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_accept && (req_func == FUNC_SOLVE)) begin
                  sink_ff     <= sink_new;
                  seg_last_ff <= seg_dec[VERTEX_BITS-1:0];
                  i_ff        <= sink_new - VERTEX_BITS'(1);
                  state_ff    <= S_ROW;
               end
            end
            S_ROW: begin
               best_ff  <= INFINITY;
               succ_ff  <= '0;
               j_ff     <= i_ff + VERTEX_BITS'(1);
               state_ff <= S_RD;
            end
            S_RD: begin
               state_ff <= S_EV;
            end
            S_EV: begin
               if (relax.take) begin
                  best_ff <= relax.cost;
                  succ_ff <= j_ff;
               end
               if (j_ff == sink_ff) begin
                  state_ff <= S_WR;
               end else begin
                  j_ff     <= j_ff + VERTEX_BITS'(1);
                  state_ff <= S_RD;
               end
            end
            S_WR: begin
               if (i_ff == '0) begin
                  state_ff <= S_CHK;
               end else begin
                  i_ff     <= i_ff - VERTEX_BITS'(1);
                  state_ff <= S_ROW;
               end
            end
            S_CHK: begin
               state_ff <= S_CHK2;
            end
            S_CHK2: begin
               if (cost_q_ff.cost == INFINITY) begin
                  // unreachable source: a single flagged result
                  rsp_valid_ff       <= 1'b1;
                  rsp_path_vertex_ff <= '0;
                  rsp_path_cost_ff   <= INFINITY;
                  rsp_unreachable_ff <= 1'b1;
                  rsp_last_ff        <= 1'b1;
                  state_ff           <= S_OUT;
               end else begin
                  total_ff <= cost_q_ff.cost;
                  cur_ff   <= '0;
                  k_ff     <= '0;
                  state_ff <= S_PATH;
               end
            end
            S_PATH: begin
               // the final vertex is always the sink
               rsp_valid_ff       <= 1'b1;
               rsp_path_vertex_ff <= (k_ff == seg_last_ff) ? sink_ff : cur_ff;
               rsp_path_cost_ff   <= total_ff;
               rsp_unreachable_ff <= 1'b0;
               rsp_last_ff        <= (k_ff == seg_last_ff);
               state_ff           <= S_OUT;
            end
            S_OUT: begin
               if (rsp_accept) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     clr_addr_ff <= '0;
                     state_ff    <= S_CLEAR;
                  end else begin
                     cur_ff   <= next_cur;
                     k_ff     <= k_ff + VERTEX_BITS'(1);
                     state_ff <= S_PATH;
                  end
               end
            end
            default: begin
               state_ff <= S_CLEAR;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_path_vertex = rsp_path_vertex_ff;
   assign rsp_path_cost   = rsp_path_cost_ff;
   assign rsp_unreachable = rsp_unreachable_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef ASSERT_OFF
   // no request is taken while a result waits
   a_no_accept_in_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall)
      else $error("request taken while a result is pending");

   // an unreachable result closes the run
   a_unreachable_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_unreachable_ff) |-> rsp_last_ff)
      else $error("unreachable result not marked last");

   // a reachable path ends at the sink
   a_path_ends_at_sink: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff && !rsp_unreachable_ff) |-> (rsp_path_vertex_ff == sink_ff))
      else $error("path does not end at the sink");

   // relaxation only looks at forward arcs
   a_forward_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EV) |-> ((j_ff > i_ff) && (j_ff <= sink_ff)))
      else $error("relaxation index out of the forward range");
`endif

endmodule
